FILE: rtl/utu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utu_pkg: shared types and constants of the UTF-8 to UTF-16 decoder
// Holds the queue entry that the classifier hands to the unit emitter,
// the queue geometry and the constants of the surrogate encoding.
// ----------------------------------------------------------------------------
package utu_pkg;

  localparam int BYTE_W  = 8;
  localparam int UNIT_W  = 16;
  localparam int ACC_W   = 21;
  localparam int LEN_W   = 3;

  // Most units that one input byte can cause: a closed surrogate pair plus
  // one unit for the byte itself.
  localparam int UNITS_MAX = 3;
  localparam int CNT_W     = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [LEN_W-1:0]  LEN_SURR    = 3'd4;
  localparam logic [ACC_W-1:0]  SURR_OFFSET = 21'h10000;
  localparam logic [5:0]        HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]        LO_SURR_TAG = 6'b110111;
  localparam logic [1:0]        CONT_TAG    = 2'b10;

  typedef struct packed {
    logic [CNT_W-1:0]                count;
    logic                            fin;
    logic [UNITS_MAX-1:0][UNIT_W-1:0] units;
  } utu_entry_t;

endpackage
`default_nettype wire

FILE: rtl/utf8_to_utf16_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_core: streaming UTF-8 to UTF-16 decoder
// Turns a byte stream into UTF-16 code units, with surrogate pairs for
// sequences of four or more bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (byte_valid, byte_stall) carries one byte per
// transaction, with final_byte marking the end of the text; a sequence still
// open at that byte is flushed. The output channel (unit_valid, unit_stall)
// carries one code unit per transaction. last_of_run flags the last unit that
// an input byte caused and end_of_text flags that unit for the final byte.
// A byte causes zero to three units.
// A byte's units pass through a queue slot and then the output register.
// Throughput: one byte per cycle as long as each byte causes at most one
// unit and unit_stall is low; the single output register drains one unit per
// cycle when not stalled, so a multi-unit byte holds the output side longer.
// A four-entry queue separates the classifier from the emitter. byte_stall
// rises only while that queue is full, so a stalled receiver holds off input
// only after the queue has filled; it never depends on unit_stall directly.
// Reset (rst, synchronous) drops any open sequence, empties the queue and
// clears unit_valid.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         byte_valid,
  output logic                              byte_stall,
  input  wire logic [utu_pkg::BYTE_W-1:0]   byte_value,
  input  wire logic                         final_byte,
  output logic                              unit_valid,
  input  wire logic                         unit_stall,
  output logic [utu_pkg::UNIT_W-1:0]        code_unit,
  output logic                              last_of_run,
  output logic                              end_of_text
);

  utu_pkg::utu_entry_t wr_entry, head;
  logic                push, pop, not_empty, full, take;

  // A byte is taken whenever the queue has room, even if it causes no unit.
  assign byte_stall = full;
  assign take       = byte_valid && !full;

  utu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .byte_value (byte_value),
    .final_byte (final_byte),
    .push       (push),
    .entry      (wr_entry)
  );

  utu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  utu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .not_empty   (not_empty),
    .pop         (pop),
    .unit_valid  (unit_valid),
    .unit_stall  (unit_stall),
    .code_unit   (code_unit),
    .last_of_run (last_of_run),
    .end_of_text (end_of_text)
  );

endmodule
`default_nettype wire

FILE: rtl/utu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utu_front: byte classifier
// Keeps the open sequence state, classifies each byte and builds one queue
// entry with all code units that the byte causes.
// ----------------------------------------------------------------------------
module utu_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire logic [utu_pkg::BYTE_W-1:0]  byte_value,
  input  wire logic                        final_byte,
  output logic                             push,
  output utu_pkg::utu_entry_t              entry
);

  logic                        seq_pending, seq_pending_next;
  logic [utu_pkg::ACC_W-1:0]   accumulator, accumulator_next;
  logic [utu_pkg::LEN_W-1:0]   seq_length, seq_length_next;

  logic                        is_cont;
  logic [utu_pkg::ACC_W-1:0]   acc_ext;
  logic [utu_pkg::LEN_W-1:0]   len_ext;
  logic [utu_pkg::ACC_W-1:0]   close_acc;
  logic [utu_pkg::LEN_W-1:0]   close_len;
  logic                        do_close;
  logic [utu_pkg::ACC_W-1:0]   surr_val;
  logic [utu_pkg::UNIT_W-1:0]  close_u0, close_u1, tail_unit;
  logic [utu_pkg::CNT_W-1:0]   close_cnt;
  logic                        tail_vld;

  always_comb begin
    is_cont = seq_pending && (byte_value[7:6] == utu_pkg::CONT_TAG);
    acc_ext = {accumulator[utu_pkg::ACC_W-7:0], byte_value[5:0]};
    len_ext = (seq_length < utu_pkg::LEN_SURR) ? seq_length + 3'd1 : seq_length;

    // A continuation byte closes its own extended sequence only on the final
    // byte; any other byte closes the sequence that was open before it.
    close_acc = is_cont ? acc_ext : accumulator;
    close_len = is_cont ? len_ext : seq_length;
    do_close  = is_cont ? final_byte : seq_pending;

    surr_val = close_acc - utu_pkg::SURR_OFFSET;
    if (close_len < utu_pkg::LEN_SURR) begin
      close_u0  = close_acc[utu_pkg::UNIT_W-1:0];
      close_u1  = close_acc[utu_pkg::UNIT_W-1:0];
      close_cnt = do_close ? 2'd1 : 2'd0;
    end else begin
      close_u0  = {utu_pkg::HI_SURR_TAG, surr_val[19:10]};
      close_u1  = {utu_pkg::LO_SURR_TAG, surr_val[9:0]};
      close_cnt = do_close ? 2'd2 : 2'd0;
    end

    // Unit for the byte itself: plain ASCII, or a lead byte that the final
    // flag flushes at once as a one-byte sequence.
    if (byte_value[7] == 1'b0) begin
      tail_unit = {8'h00, byte_value};
      tail_vld  = !is_cont;
    end else begin
      tail_unit = {11'h000, byte_value[4:0]};
      tail_vld  = !is_cont && final_byte;
    end

    entry.fin      = final_byte;
    entry.count    = close_cnt + {1'b0, tail_vld};
    entry.units[0] = (close_cnt != 2'd0) ? close_u0 : tail_unit;
    entry.units[1] = (close_cnt == 2'd2) ? close_u1 : tail_unit;
    entry.units[2] = tail_unit;
    push           = take && (entry.count != 2'd0);

    seq_pending_next = seq_pending;
    accumulator_next = accumulator;
    seq_length_next  = seq_length;
    if (take) begin
      if (final_byte || (!is_cont && byte_value[7] == 1'b0)) begin
        seq_pending_next = 1'b0;
        accumulator_next = '0;
        seq_length_next  = '0;
      end else if (is_cont) begin
        accumulator_next = acc_ext;
        seq_length_next  = len_ext;
      end else begin
        seq_pending_next = 1'b1;
        accumulator_next = {16'h0000, byte_value[4:0]};
        seq_length_next  = 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_pending <= 1'b0;
      accumulator <= '0;
      seq_length  <= '0;
    end else begin
      seq_pending <= seq_pending_next;
      accumulator <= accumulator_next;
      seq_length  <= seq_length_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/utu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utu_queue: entry queue
// Small first-in first-out queue of classified bytes between the
// classifier and the unit emitter.
// ----------------------------------------------------------------------------
module utu_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire utu_pkg::utu_entry_t  wr_entry,
  input  wire logic                 pop,
  output utu_pkg::utu_entry_t       head,
  output logic                      not_empty,
  output logic                      full
);

  utu_pkg::utu_entry_t               slots [utu_pkg::QUEUE_DEPTH];
  logic [utu_pkg::QPTR_W-1:0]        wr_ptr, rd_ptr;
  logic [utu_pkg::QCNT_W-1:0]        fill, fill_next;

  assign head      = slots[rd_ptr];
  assign not_empty = (fill != '0);
  assign full      = (fill == utu_pkg::QCNT_W'(utu_pkg::QUEUE_DEPTH));

  always_comb begin
    fill_next = fill;
    if (push && !pop)      fill_next = fill + 1'b1;
    else if (!push && pop) fill_next = fill - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/utu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utu_back: unit emitter
// Walks the units of the head queue entry one per cycle, while the output is
// not stalled, into the output register and pops the entry after its last unit.
// ----------------------------------------------------------------------------
module utu_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire utu_pkg::utu_entry_t          head,
  input  wire logic                         not_empty,
  output logic                              pop,
  output logic                              unit_valid,
  input  wire logic                         unit_stall,
  output logic [utu_pkg::UNIT_W-1:0]        code_unit,
  output logic                              last_of_run,
  output logic                              end_of_text
);

  logic [utu_pkg::CNT_W-1:0] idx, idx_next;
  logic                      load, is_last, unit_valid_next;

  always_comb begin
    load            = !unit_valid || !unit_stall;
    is_last         = (idx == head.count - 2'd1);
    pop             = load && not_empty && is_last;
    unit_valid_next = load ? not_empty : unit_valid;
    idx_next        = idx;
    if (load && not_empty) idx_next = is_last ? '0 : idx + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
      idx        <= '0;
    end else begin
      unit_valid <= unit_valid_next;
      idx        <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && not_empty) begin
      code_unit   <= head.units[idx];
      last_of_run <= is_last;
      end_of_text <= is_last && head.fin;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/utu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utu_checker: port-level checks of the decoder
// Watches the top-level ports and flags broken output sequencing.
// ----------------------------------------------------------------------------
module utu_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        unit_valid,
  input wire logic                        unit_stall,
  input wire logic [utu_pkg::UNIT_W-1:0]  code_unit,
  input wire logic                        last_of_run,
  input wire logic                        end_of_text
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    unit_valid && unit_stall |=> unit_valid && $stable(code_unit))
    else $error("stalled code unit changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !unit_valid)
    else $error("unit_valid high right after reset");

  a_eot_last: assert property (@(posedge clk) disable iff (rst)
    unit_valid && end_of_text |-> last_of_run)
    else $error("end_of_text on a unit that is not last of its run");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    unit_valid && !unit_stall && !last_of_run |=> unit_valid)
    else $error("run of units broken off");

endmodule

bind utf8_to_utf16_decoder_core utu_checker u_utu_checker (
  .clk         (clk),
  .rst         (rst),
  .unit_valid  (unit_valid),
  .unit_stall  (unit_stall),
  .code_unit   (code_unit),
  .last_of_run (last_of_run),
  .end_of_text (end_of_text)
);
`default_nettype wire
